FILE: sv/pcsl_pkg.sv
// Package for the parity-check syndrome locator: sizes, codes, the result
// record and the matrix helper functions. It depends on nothing else.
package pcsl_pkg;

    localparam int ROWS       = 8;
    localparam int COLS       = 16;
    localparam int REG_COUNT  = 8;
    localparam int REG_W      = 16;
    localparam int SYN_W      = 8;
    localparam int POS_W      = 4;
    localparam int IDX_W      = $clog2(COLS);
    localparam int CFG_IDX_W  = 3;
    localparam int DATA_IN_W  = 16;
    localparam int DATA_OUT_W = 24;

    typedef logic [REG_COUNT-1:0][REG_W-1:0] h_rows_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_PAIR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STATUS_SINGLE = 2'd0,
        STATUS_PAIR   = 2'd1,
        STATUS_NONE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [SYN_W-1:0] syndrome;
        status_t          status;
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
    } result_t;

    // Column c of the matrix, bit r is row r. Columns past the register width read as zero.
    function automatic logic [ROWS-1:0] column_of(h_rows_t h, logic [IDX_W-1:0] c);
        logic [ROWS-1:0] col;
        logic [31:0]     ci;
        col = '0;
        ci  = 32'(c);
        for (int r = 0; r < ROWS; r++)
        begin
            if (ci < 32'(REG_W))
            begin
                col[r] = h[r][ci[3:0]];
            end
        end
        return col;
    endfunction

    function automatic logic [SYN_W-1:0] syndrome_of(h_rows_t h, logic [REG_W-1:0] word);
        logic [SYN_W-1:0] syn;
        syn = '0;
        for (int r = 0; r < SYN_W; r++)
        begin
            if (r < ROWS)
            begin
                syn[r] = ^(h[r] & word);
            end
        end
        return syn;
    endfunction

endpackage

FILE: sv/pcsl_search.sv
// Syndrome former and ordered column search with one shared XOR-compare unit.
// Depends on pcsl_pkg.
module pcsl_search
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pcsl_pkg::h_rows_t         h_rows,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [pcsl_pkg::REG_W-1:0] in_word,
    output logic                      res_valid,
    input  logic                      res_ready,
    output pcsl_pkg::result_t         res
);

    localparam logic [pcsl_pkg::IDX_W-1:0] LAST_J = pcsl_pkg::IDX_W'(pcsl_pkg::COLS - 1);
    localparam logic [pcsl_pkg::IDX_W-1:0] LAST_I = pcsl_pkg::IDX_W'(pcsl_pkg::COLS - 2);

    pcsl_pkg::state_t               state_reg, state_next;
    logic [pcsl_pkg::IDX_W-1:0]     i_reg, i_next;
    logic [pcsl_pkg::IDX_W-1:0]     j_reg, j_next;
    logic [pcsl_pkg::SYN_W-1:0]     syn_reg, syn_next;
    pcsl_pkg::result_t              res_reg, res_next;

    logic [pcsl_pkg::ROWS-1:0]      col_a;
    logic [pcsl_pkg::ROWS-1:0]      col_b;
    logic                           hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcsl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        syn_reg <= syn_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        col_a = pcsl_pkg::column_of(h_rows, i_reg);
        col_b = (state_reg == pcsl_pkg::ST_PAIR) ? pcsl_pkg::column_of(h_rows, j_reg) : '0;
        hit   = ((col_a ^ col_b) == syn_reg[pcsl_pkg::ROWS-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        syn_next   = syn_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            pcsl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    syn_next   = pcsl_pkg::syndrome_of(h_rows, in_word);
                    i_next     = '0;
                    j_next     = '0;
                    state_next = pcsl_pkg::ST_SINGLE;
                end
            end
            pcsl_pkg::ST_SINGLE:
            begin
                if (hit)
                begin
                    res_next.syndrome        = syn_reg;
                    res_next.status          = pcsl_pkg::STATUS_SINGLE;
                    res_next.first_position  = pcsl_pkg::POS_W'(i_reg);
                    res_next.second_position = '0;
                    state_next               = pcsl_pkg::ST_DONE;
                end
                else if (i_reg == LAST_J)
                begin
                    i_next     = '0;
                    j_next     = pcsl_pkg::IDX_W'(1);
                    state_next = pcsl_pkg::ST_PAIR;
                end
                else
                begin
                    i_next = i_reg + pcsl_pkg::IDX_W'(1);
                end
            end
            pcsl_pkg::ST_PAIR:
            begin
                if (hit)
                begin
                    res_next.syndrome        = syn_reg;
                    res_next.status          = pcsl_pkg::STATUS_PAIR;
                    res_next.first_position  = pcsl_pkg::POS_W'(i_reg);
                    res_next.second_position = pcsl_pkg::POS_W'(j_reg);
                    state_next               = pcsl_pkg::ST_DONE;
                end
                else if (j_reg == LAST_J)
                begin
                    if (i_reg == LAST_I)
                    begin
                        res_next.syndrome        = syn_reg;
                        res_next.status          = pcsl_pkg::STATUS_NONE;
                        res_next.first_position  = '0;
                        res_next.second_position = '0;
                        state_next               = pcsl_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + pcsl_pkg::IDX_W'(1);
                        j_next = i_reg + pcsl_pkg::IDX_W'(2);
                    end
                end
                else
                begin
                    j_next = j_reg + pcsl_pkg::IDX_W'(1);
                end
            end
            pcsl_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = pcsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcsl_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == pcsl_pkg::ST_SINGLE))
        else $error("Accepted request did not start the column search.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcsl_pkg::ST_PAIR) |-> (j_reg > i_reg))
        else $error("Pair search left the i below j order.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("Pending result changed before it was taken.");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_reg.status == pcsl_pkg::STATUS_NONE))
        |-> ((res_reg.first_position == '0) && (res_reg.second_position == '0)))
        else $error("No-match result carries a nonzero position.");

endmodule

FILE: sv/parity_check_syndrome_locator_unit.sv
// Top level of the parity-check syndrome locator: matrix row registers, the
// search sequencer and the output register. Depends on pcsl_pkg and pcsl_search.
// Flow: a request is taken in the idle state; the single-column compares and, if none
// hits, the column-pair compares run, one per cycle in the shared XOR-compare unit;
// the result waits in the done state for the output register before the next request.
// Reset clears the matrix rows to zero and empties the block; no clearing pass.
module parity_check_syndrome_locator_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pcsl_pkg::DATA_IN_W-1:0]    s_axis_tdata,  // received_word
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // syndrome[7:0], status[9:8], first_position[13:10], second_position[17:14], zero pad
    output logic [pcsl_pkg::DATA_OUT_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcsl_pkg::REG_W-1:0]        cfg_data
);

    pcsl_pkg::h_rows_t                  h_rows_reg;
    logic                               out_valid_reg;
    logic [pcsl_pkg::DATA_OUT_W-1:0]    out_data_reg;

    logic                               res_valid;
    logic                               res_ready;
    pcsl_pkg::result_t                  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_rows_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            h_rows_reg[cfg_index] <= cfg_data;
        end
    end

    pcsl_search u_search
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .h_rows    (h_rows_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {6'b0, res.second_position, res.first_position,
                             res.status, res.syndrome};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: test/pcsl_checker.sv
// Checker for parity_check_syndrome_locator_unit: tracks the matrix rows written on the
// configuration channel, predicts one result per accepted received word and compares
// every output request in order. Depends on pcsl_pkg for sizes and the result record.
module pcsl_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [pcsl_pkg::DATA_IN_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pcsl_pkg::DATA_OUT_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [pcsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcsl_pkg::REG_W-1:0]        cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                single_count,
    output int                                pair_count,
    output int                                none_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    pcsl_pkg::h_rows_t h_copy;
    pcsl_pkg::result_t expected_q[$];
    int                result_count;

    function automatic pcsl_pkg::result_t locate_errors(pcsl_pkg::h_rows_t h,
                                                        logic [pcsl_pkg::REG_W-1:0] word);
        pcsl_pkg::result_t          res;
        logic [pcsl_pkg::ROWS-1:0]  col [pcsl_pkg::COLS];
        logic [pcsl_pkg::SYN_W-1:0] syn;
        bit                         found;
        res        = '0;
        res.status = pcsl_pkg::STATUS_NONE;
        found      = 1'b0;
        syn        = '0;
        for (int c = 0; c < pcsl_pkg::COLS; c++)
        begin
            for (int r = 0; r < pcsl_pkg::ROWS; r++)
            begin
                col[c][r] = (c < pcsl_pkg::REG_W) ? h[r][c] : 1'b0;
            end
        end
        for (int r = 0; r < pcsl_pkg::ROWS; r++)
        begin
            syn[r] = ^(h[r] & word);
        end
        res.syndrome = syn;
        for (int c = 0; c < pcsl_pkg::COLS && !found; c++)
        begin
            if (col[c] == syn)
            begin
                res.status         = pcsl_pkg::STATUS_SINGLE;
                res.first_position = pcsl_pkg::POS_W'(c);
                found              = 1'b1;
            end
        end
        for (int i = 0; i + 1 < pcsl_pkg::COLS && !found; i++)
        begin
            for (int j = i + 1; j < pcsl_pkg::COLS && !found; j++)
            begin
                if ((col[i] ^ col[j]) == syn)
                begin
                    res.status          = pcsl_pkg::STATUS_PAIR;
                    res.first_position  = pcsl_pkg::POS_W'(i);
                    res.second_position = pcsl_pkg::POS_W'(j);
                    found               = 1'b1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pcsl_pkg::result_t          want;
        logic [pcsl_pkg::SYN_W-1:0] got_syn;
        logic [1:0]                 got_status;
        logic [pcsl_pkg::POS_W-1:0] got_first;
        logic [pcsl_pkg::POS_W-1:0] got_second;
        if (!rst_n)
        begin
            h_copy = '0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_syn    = m_tdata[7:0];
                got_status = m_tdata[9:8];
                got_first  = m_tdata[13:10];
                got_second = m_tdata[17:14];
                result_count++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("result %0d arrived with no request outstanding: data %06h",
                                 result_count, m_tdata);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    case (want.status)
                        pcsl_pkg::STATUS_SINGLE: single_count++;
                        pcsl_pkg::STATUS_PAIR:   pair_count++;
                        default:                 none_count++;
                    endcase
                    if (got_syn != want.syndrome || got_status != want.status
                        || got_first != want.first_position
                        || got_second != want.second_position)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display({"result %0d mismatch: expected syndrome %02h status %0d ",
                                      "positions %0d/%0d, got syndrome %02h status %0d ",
                                      "positions %0d/%0d"},
                                     result_count, want.syndrome, want.status,
                                     want.first_position, want.second_position,
                                     got_syn, got_status, got_first, got_second);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_q.insert(expected_q.size(), locate_errors(h_copy, s_tdata));
            end
            if (cfg_valid && cfg_ready)
            begin
                h_copy[cfg_index] = cfg_data;
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for parity_check_syndrome_locator_unit: clock, reset, matrix writes,
// received-word stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on pcsl_pkg, the block itself and pcsl_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 40;
    localparam int WORDS_PER_SET  = 40;
    localparam int END_WAIT       = 150;

    typedef enum int {
        MX_RANDOM,
        MX_DISTINCT,
        MX_NARROW,
        MX_SPARSE
    } matrix_kind_t;

    typedef logic [pcsl_pkg::COLS-1:0][pcsl_pkg::ROWS-1:0] h_cols_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [pcsl_pkg::DATA_IN_W-1:0]    s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [pcsl_pkg::DATA_OUT_W-1:0]   m_axis_tdata;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [pcsl_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [pcsl_pkg::REG_W-1:0]        cfg_data;

    int fail_count;
    int pending;
    int single_count;
    int pair_count;
    int none_count;

    int send_gap_max;
    int recv_gap_max;
    bit long_hold_due;
    int idle_cycles;
    int words_sent;
    int settings_count;
    int write_count;

    parity_check_syndrome_locator_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pcsl_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .single_count (single_count),
        .pair_count   (pair_count),
        .none_count   (none_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("parity_check_syndrome_locator_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        bit hold_taken;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, recv_gap_max);
            if (long_hold_due && !hold_taken)
            begin
                gap        = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    task automatic send_word(input logic [pcsl_pkg::REG_W-1:0] word);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
        words_sent++;
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_matrix(input pcsl_pkg::h_rows_t rows);
        for (int r = 0; r < pcsl_pkg::REG_COUNT; r++)
        begin
            cfg_index <= pcsl_pkg::CFG_IDX_W'(r);
            cfg_data  <= rows[r];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
            @(negedge clk);
            write_count++;
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    function automatic pcsl_pkg::h_rows_t rows_from_columns(h_cols_t cols);
        pcsl_pkg::h_rows_t rows;
        rows = '0;
        for (int c = 0; c < pcsl_pkg::COLS; c++)
        begin
            for (int r = 0; r < pcsl_pkg::ROWS; r++)
            begin
                rows[r][c] = cols[c][r];
            end
        end
        return rows;
    endfunction

    function automatic h_cols_t make_columns(matrix_kind_t kind);
        h_cols_t                   cols;
        logic [pcsl_pkg::ROWS-1:0] mask;
        logic [pcsl_pkg::ROWS-1:0] step;
        logic [pcsl_pkg::ROWS-1:0] offset;
        mask   = pcsl_pkg::ROWS'((1 << $urandom_range(1, 3)) - 1) << $urandom_range(0, 5);
        step   = pcsl_pkg::ROWS'($urandom_range(0, 255)) | pcsl_pkg::ROWS'(1);
        offset = pcsl_pkg::ROWS'($urandom_range(0, 255));
        for (int c = 0; c < pcsl_pkg::COLS; c++)
        begin
            case (kind)
                MX_DISTINCT: cols[c] = pcsl_pkg::ROWS'(c) * step + offset;
                MX_NARROW:   cols[c] = pcsl_pkg::ROWS'($urandom_range(0, 255)) & mask;
                MX_SPARSE:   cols[c] = ($urandom_range(0, 4) == 0) ? '0
                                       : pcsl_pkg::ROWS'(1)
                                         << $urandom_range(0, pcsl_pkg::ROWS - 1);
                default:     cols[c] = pcsl_pkg::ROWS'($urandom_range(0, 255));
            endcase
        end
        return cols;
    endfunction

    // Mostly words with a few flipped bits, so that single and pair searches hit often.
    function automatic logic [pcsl_pkg::REG_W-1:0] random_word();
        logic [pcsl_pkg::REG_W-1:0] w;
        int                         pick;
        int                         flips;
        int                         idx;
        pick = $urandom_range(0, 9);
        w    = '0;
        if (pick >= 8)
        begin
            w = pcsl_pkg::REG_W'($urandom);
        end
        else
        begin
            flips = (pick == 0) ? 0 : (pick <= 3) ? 1 : (pick <= 6) ? 2 : 3;
            for (int k = 0; k < flips; k++)
            begin
                idx    = $urandom_range(0, pcsl_pkg::REG_W - 1);
                w[idx] = ~w[idx];
            end
        end
        return w;
    endfunction

    initial
    begin
        h_cols_t           cols;
        pcsl_pkg::h_rows_t rows;
        matrix_kind_t      kind;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_gap_max   = 0;
        recv_gap_max   = 0;
        long_hold_due  = 1'b0;
        words_sent     = 0;
        settings_count = 0;
        write_count    = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The all-zero matrix after reset matches column zero for every word.
        send_word(16'h0000);
        send_word(16'hFFFF);
        settle_block();

        for (int c = 0; c < pcsl_pkg::COLS; c++)
        begin
            cols[c] = pcsl_pkg::ROWS'(c + 1);
        end
        write_matrix(rows_from_columns(cols));
        send_word(16'h0000);
        send_word(16'h0001);
        send_word(16'h8000);
        send_word(16'h0003);
        send_word(16'h8001);
        send_word(16'hFFFF);
        send_word(16'h00F0);
        settle_block();

        send_gap_max = 11;
        recv_gap_max = 11;
        write_matrix({pcsl_pkg::REG_COUNT{16'hFFFF}});
        send_word(16'h0000);
        send_word(16'h0001);
        send_word(16'hFFFF);
        settle_block();

        for (int r = 0; r < pcsl_pkg::REG_COUNT; r++)
        begin
            rows[r] = r[0] ? 16'h5555 : 16'hAAAA;
        end
        write_matrix(rows);
        send_word(16'h5555);
        send_word(16'hAAAA);
        send_word(16'h0003);
        settle_block();

        write_matrix('0);
        send_word(16'h1234);
        settle_block();

        for (int p = 0; p < PHASES; p++)
        begin
            kind = matrix_kind_t'($urandom_range(0, 3));
            write_matrix(rows_from_columns(make_columns(kind)));
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            if (p == 5)
            begin
                long_hold_due = 1'b1;
            end
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                send_word(random_word());
            end
            settle_block();
        end

        repeat (END_WAIT) @(negedge clk);
        $display("Checked %0d received words across %0d matrix settings (%0d row writes).",
                 words_sent, settings_count, write_count);
        $display("Outcomes: %0d single-column, %0d column-pair, %0d no-match results.",
                 single_count, pair_count, none_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("parity_check_syndrome_locator_unit regression: pass");
        end
        else
        begin
            $display("parity_check_syndrome_locator_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/pcsl_pkg.sv
sv/pcsl_search.sv
sv/parity_check_syndrome_locator_unit.sv
test/pcsl_checker.sv
test/tb.sv
